@@ rtl/amicable_perfect_classifier_core_assert.svh @@
// ============================================================================
// Assertion macros for the amicable/perfect classifier
// Concurrent assertion wrappers clocked on clock and disabled during reset.
// ============================================================================
`ifndef AMICABLE_PERFECT_CLASSIFIER_CORE_ASSERT_SVH
`define AMICABLE_PERFECT_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define APC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("classifier assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("classifier assertion failed");

`else

`define APC_ASSERT_SAME(label, ante, cons)
`define APC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/apc_pkg.sv @@
// ============================================================================
// apc_pkg
// Shared constants and types of the amicable/perfect classifier.
// ============================================================================
package apc_pkg;

   // Default width of the number under test.
   localparam int NUMBER_WIDTH_DEFAULT = 24;

   // Width and saturation value of the reported divisor sum.
   localparam int               SUM_WIDTH = 27;
   localparam logic [26:0]      SUM_MAX   = 27'h7FF_FFFF;

   // Result data bus: divisor sum padded to whole bytes.
   localparam int RSP_DATA_WIDTH = 32;
   localparam int RSP_PAD_WIDTH  = RSP_DATA_WIDTH - SUM_WIDTH;

   // Classification codes.
   localparam int KIND_WIDTH = 2;
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_NONE     = 2'd0,
      KIND_PERFECT  = 2'd1,
      KIND_AMICABLE = 2'd2
   } kind_type;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_START  = 6'b000010,
      S_TEST   = 6'b000100,
      S_DIVIDE = 6'b001000,
      S_ACCUM  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

endpackage

@@ rtl/apc_divider.sv @@
// ============================================================================
// apc_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ============================================================================
module apc_divider #(
   parameter int WIDTH = apc_pkg::SUM_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   import apc_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff,  busy_in;
   logic             done_ff,  done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH-1:0] quot_ff,  quot_in;
   logic [WIDTH-1:0] rem_ff,   rem_in;
   logic [WIDTH-1:0] dvsr_ff,  dvsr_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, quot_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign fits  = trial >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(WIDTH);
         quot_in  = dividend;
         rem_in   = '0;
         dvsr_in  = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[WIDTH-2:0], fits};
         rem_in   = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the data path is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/amicable_perfect_classifier_core.sv @@
// ============================================================================
// amicable_perfect_classifier_core
// Forms the aliquot sum s of a number n by trial division, then the aliquot
// sum of s, and classifies n as none, perfect or amicable.
// ============================================================================
//
//  Channel | Direction | Contents
//  --------+-----------+---------------------------------------------------
//  req     | in        | tdata: number
//  rsp     | out       | tdata: divisor_sum (27 bits, zero padded); tuser: kind
//
// One item is worked on at a time. Each trial divisor d (2 up to floor(sqrt(m)))
// is tried by one run of the bit-serial divider, of width max(NUMBER_WIDTH, 27).
// The second pass, over s, is skipped for zero, perfect numbers and saturated
// sums.
// Reset is synchronous and clears only control state.
// A result waiting on rsp does not block the next transfer on req; a finished
// item waits in the last state only while the output register is still full.
// ============================================================================
`include "amicable_perfect_classifier_core_assert.svh"

module amicable_perfect_classifier_core #(
   parameter int NUMBER_WIDTH = apc_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata fields from bit 0: number
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]    req_tdata,
   // rsp_tdata fields from bit 0: divisor_sum, zero padding
   // rsp_tuser fields from bit 0: kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [apc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [apc_pkg::KIND_WIDTH-1:0]       rsp_tuser
);
   import apc_pkg::*;

   // Data path widths.
   localparam int DW    = (NUMBER_WIDTH > SUM_WIDTH) ? NUMBER_WIDTH : SUM_WIDTH;
   localparam int ACC_W = DW + 3;
   localparam int SQ_W  = DW + 1;
   localparam int D_W   = (DW + 1) / 2 + 1;

   state_type               state_ff,     state_in;
   logic [NUMBER_WIDTH-1:0] n_ff,         n_in;
   logic [DW-1:0]           m_ff,         m_in;
   logic [D_W-1:0]          d_ff,         d_in;
   logic [SQ_W-1:0]         sq_ff,        sq_in;
   logic [ACC_W-1:0]        total_ff,     total_in;
   logic                    pass_ff,      pass_in;
   logic [SUM_WIDTH-1:0]    first_sum_ff, first_sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUM_WIDTH-1:0]    rsp_sum_ff,   rsp_sum_in;
   kind_type                rsp_kind_ff,  rsp_kind_in;

   logic                    req_accept;
   logic                    div_start;
   logic                    div_done;
   logic [DW-1:0]           div_quot;
   logic [DW-1:0]           div_rem;
   logic                    sq_over;
   logic                    total_over;
   logic                    total_eq_n;
   logic                    add_quot;
   logic                    emit;
   logic [SUM_WIDTH-1:0]    emit_sum;
   kind_type                emit_kind;

   // Shared bit-serial divider computing m / d and m % d.
   apc_divider #(
      .WIDTH (DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (m_ff),
      .divisor   (DW'(d_ff)),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Comparisons used by the sequencer.
   assign req_accept = req_tvalid && req_tready;
   assign sq_over    = sq_ff > {1'b0, m_ff};
   assign total_over = total_ff > ACC_W'(SUM_MAX);
   assign total_eq_n = total_ff == ACC_W'(n_ff);
   assign add_quot   = div_quot != DW'(d_ff);

   // Result of a finished pass.
   always_comb begin
      emit      = 1'b0;
      emit_sum  = total_ff[SUM_WIDTH-1:0];
      emit_kind = KIND_NONE;
      if (pass_ff) begin
         emit      = 1'b1;
         emit_sum  = first_sum_ff;
         emit_kind = total_eq_n ? KIND_AMICABLE : KIND_NONE;
      end else if (total_over) begin
         emit      = 1'b1;
         emit_sum  = SUM_MAX;
      end else if (n_ff == '0) begin
         emit      = 1'b1;
      end else if (total_eq_n) begin
         emit      = 1'b1;
         emit_kind = KIND_PERFECT;
      end
   end

   // Sequencer: one or two passes of trial division over d = 2 .. floor(sqrt(m)).
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      total_in     = total_ff;
      pass_in      = pass_ff;
      first_sum_in = first_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_kind_in  = rsp_kind_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               n_in     = req_tdata[NUMBER_WIDTH-1:0];
               m_in     = DW'(req_tdata[NUMBER_WIDTH-1:0]);
               pass_in  = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (m_ff < DW'(2)) begin
               total_in = '0;
               state_in = S_FINISH;
            end else begin
               total_in = ACC_W'(1);
               d_in     = D_W'(2);
               sq_in    = SQ_W'(4);
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (sq_over) begin
               state_in = S_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            // A divisor found: add d and its cofactor, once for a square.
            if (div_rem == '0) begin
               total_in = total_ff + ACC_W'(d_ff) + (add_quot ? ACC_W'(div_quot) : '0);
            end
            d_in     = d_ff + D_W'(1);
            sq_in    = sq_ff + SQ_W'({d_ff, 1'b0}) + SQ_W'(1);
            state_in = S_TEST;
         end
         S_FINISH: begin
            if (emit) begin
               if (!rsp_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = emit_sum;
                  rsp_kind_in  = emit_kind;
                  state_in     = S_IDLE;
               end
            end else begin
               // Second pass over the partner candidate.
               first_sum_in = total_ff[SUM_WIDTH-1:0];
               m_in         = DW'(total_ff);
               pass_in      = 1'b1;
               state_in     = S_START;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      m_ff         <= m_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      total_ff     <= total_in;
      pass_ff      <= pass_in;
      first_sum_ff <= first_sum_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   // Ports.
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_WIDTH{1'b0}}, rsp_sum_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // An accepted transfer always starts a pass.
   `APC_ASSERT_NEXT(a_accept_starts, req_accept, state_ff == S_START)
   // The divider only finishes while the sequencer waits for it.
   `APC_ASSERT_SAME(a_div_done_in_divide, div_done, state_ff == S_DIVIDE)
   // A delivered result is never replaced by a new one in the same edge.
   `APC_ASSERT_NEXT(a_no_overwrite, rsp_tvalid && rsp_tready, !rsp_tvalid)

endmodule

@@ tb/sv/classification_checker.sv @@
// ----------------------------------------------------------------------------
// classification_checker
// Watches both streams of the amicable/perfect classifier. It works out the
// aliquot sum and the class of every accepted number, and compares each
// result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module classification_checker #(
   parameter int NUMBER_WIDTH = apc_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [apc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic [apc_pkg::KIND_WIDTH-1:0]       rsp_tuser,
   output int                                   error_count,
   output int                                   outstanding,
   output int                                   results_checked,
   output int                                   perfect_seen,
   output int                                   amicable_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   import apc_pkg::*;

   // One predicted result, with the number that caused it for reporting.
   typedef struct {
      logic [NUMBER_WIDTH-1:0] number;
      logic [SUM_WIDTH-1:0]    divisor_sum;
      kind_type                kind;
   } classification_type;

   classification_type expected_classes[$];

   // Sum of the proper divisors; divisors are paired with their cofactors.
   function automatic longint unsigned aliquot_total(longint unsigned value);
      longint unsigned total;
      longint unsigned divisor;
      if (value < 2)
         return 0;
      total = 1;
      for (divisor = 2; divisor * divisor <= value; divisor++) begin
         if (value % divisor == 0) begin
            total += divisor;
            if (value / divisor != divisor)
               total += value / divisor;
         end
      end
      return total;
   endfunction

   // Predicted divisor sum and class of one number.
   function automatic classification_type classify_number(logic [NUMBER_WIDTH-1:0] number);
      classification_type verdict;
      longint unsigned sum;
      sum = aliquot_total(64'(number));
      verdict.number = number;
      verdict.kind   = KIND_NONE;
      if (sum > SUM_MAX) begin
         sum = SUM_MAX;
      end else if (number != 0) begin
         if (sum == number)
            verdict.kind = KIND_PERFECT;
         else if (aliquot_total(sum) == number)
            verdict.kind = KIND_AMICABLE;
      end
      verdict.divisor_sum = sum[SUM_WIDTH-1:0];
      return verdict;
   endfunction

   // Results are matched first, so a prediction pushed in this cycle is never
   // compared with a transfer that happens in the same cycle.
   always @(posedge clock) begin
      classification_type oldest;
      if (reset) begin
         expected_classes.delete();
         error_count     = 0;
         outstanding     = 0;
         results_checked = 0;
         perfect_seen    = 0;
         amicable_seen   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_classes.size() == 0) begin
               $error("result transfer with no number outstanding: sum %0d, kind %0d",
                      rsp_tdata[SUM_WIDTH-1:0], rsp_tuser);
               error_count++;
            end else begin
               oldest = expected_classes.pop_front();
               results_checked++;
               if (oldest.kind == KIND_PERFECT)
                  perfect_seen++;
               if (oldest.kind == KIND_AMICABLE)
                  amicable_seen++;
               if (rsp_tdata[SUM_WIDTH-1:0] !== oldest.divisor_sum) begin
                  $error("divisor_sum for number %0d: expected %0d, actual %0d",
                         oldest.number, oldest.divisor_sum, rsp_tdata[SUM_WIDTH-1:0]);
                  error_count++;
               end
               if (rsp_tdata[RSP_DATA_WIDTH-1:SUM_WIDTH] !== '0) begin
                  $error("padding for number %0d: expected %0d, actual %0d",
                         oldest.number, 0, rsp_tdata[RSP_DATA_WIDTH-1:SUM_WIDTH]);
                  error_count++;
               end
               if (rsp_tuser !== oldest.kind) begin
                  $error("kind for number %0d: expected %0d, actual %0d",
                         oldest.number, oldest.kind, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_classes.insert(expected_classes.size(),
                                    classify_number(req_tdata[NUMBER_WIDTH-1:0]));
         outstanding = expected_classes.size();
      end
   end

endmodule

@@ tb/sv/tb_amicable_perfect_classifier_core.sv @@
// ----------------------------------------------------------------------------
// tb_amicable_perfect_classifier_core
// Drives numbers into the classifier: a directed set of edge values, perfect
// numbers and amicable pairs, a back-pressure stretch, then random numbers
// under three mixes of sender and receiver stalls. The checker beside the
// block predicts every result and counts the failures.
// ----------------------------------------------------------------------------
module tb_amicable_perfect_classifier_core;

   timeunit 1ns;
   timeprecision 1ps;

   import apc_pkg::*;

   localparam int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT;
   localparam int REQ_WIDTH    = ((NUMBER_WIDTH + 7) / 8) * 8;
   localparam int STALL_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 4000;

   // Edge values, small squares of primes, perfect numbers, amicable pairs
   // and the all-ones number; the first entry sits in the lowest bits.
   localparam int DIRECTED_COUNT = 21;
   localparam logic [DIRECTED_COUNT*24-1:0] DIRECTED_NUMBERS = {
      24'd16777215, 24'd76084, 24'd63020, 24'd14595, 24'd12285, 24'd1210,
      24'd1184, 24'd284, 24'd220, 24'd8128, 24'd496, 24'd28, 24'd6, 24'd12,
      24'd25, 24'd9, 24'd4, 24'd3, 24'd2, 24'd1, 24'd0
   };

   // Perfect numbers and members of amicable pairs for the random part.
   localparam int NOTABLE_COUNT = 20;
   localparam logic [NOTABLE_COUNT*24-1:0] NOTABLE_NUMBERS = {
      24'd18416, 24'd17296, 24'd14595, 24'd12285, 24'd10856, 24'd10744,
      24'd6368, 24'd6232, 24'd5564, 24'd5020, 24'd2924, 24'd2620, 24'd1210,
      24'd1184, 24'd284, 24'd220, 24'd8128, 24'd496, 24'd28, 24'd6
   };

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [REQ_WIDTH-1:0]        req_tdata;   // fields from bit 0: number
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;   // fields from bit 0: divisor_sum, padding
   logic [KIND_WIDTH-1:0]       rsp_tuser;   // fields from bit 0: kind

   int error_count;
   int outstanding;
   int results_checked;
   int perfect_seen;
   int amicable_seen;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int holds_done = 0;
   int quiet_cycles = 0;

   amicable_perfect_classifier_core #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   classification_checker #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .error_count     (error_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .perfect_seen    (perfect_seen),
      .amicable_seen   (amicable_seen)
   );

   // Clock with a 20 ns period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles.", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one number and returns at the falling edge after its transfer.
   task automatic send_number(input logic [NUMBER_WIDTH-1:0] number);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_WIDTH'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_WIDTH'(number);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drops the request so that a pause may follow.
   task automatic go_quiet();
      req_tvalid <= 1'b0;
      req_tdata  <= REQ_WIDTH'($urandom);
      @(negedge clock);
   endtask

   // Mostly small numbers, which keep the trial division short.
   function automatic logic [NUMBER_WIDTH-1:0] pick_number();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20)
         return NOTABLE_NUMBERS[$urandom_range(NOTABLE_COUNT-1)*24 +: 24];
      else if (roll < 30)
         return NUMBER_WIDTH'($urandom_range(32767, 4096));
      else if (roll < 35)
         return NUMBER_WIDTH'($urandom_range(16));
      else
         return NUMBER_WIDTH'($urandom_range(4095, 1));
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_number(pick_number());
   endtask

   // Stimulus and verdict.
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      hold_requests = 0;
      send_idle_pct = 28;
      recv_idle_pct = 66;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_number(DIRECTED_NUMBERS[i*24 +: 24]);

      // The sender pauses until every result is back, then keeps offering
      // while the receiver holds off, so the block fills and stalls its input.
      go_quiet();
      while (outstanding != 0) @(negedge clock);
      hold_requests++;
      send_idle_pct = 0;
      for (int i = 0; i < 6; i++)
         send_number(NUMBER_WIDTH'($urandom_range(60, 2)));
      go_quiet();
      while (holds_done < hold_requests || outstanding != 0) @(negedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 66;
      send_random(25);
      send_idle_pct = 66;
      recv_idle_pct = 28;
      send_random(25);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(23);

      // Drain, then leave time for any stray result to show up.
      go_quiet();
      while (outstanding != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("Checked %0d classifications (%0d perfect, %0d amicable) over edge values,",
               results_checked, perfect_seen, amicable_seen);
      $display("random numbers, three stall mixes and a full back-pressure stretch.");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
